/* hdl/bcde_pkg.sv */
// bcde_pkg: shared types and constants of the braille cell depth encoder
`timescale 1ns / 1ps

package bcde_pkg;

  // configuration register widths and indexes
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd160;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd96;

  // result kinds
  localparam logic [1:0] KIND_BLANK   = 2'd0;
  localparam logic [1:0] KIND_GLYPH   = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;

  // byte codes of the emitted characters
  localparam logic [7:0] UTF8_LEAD_GLYPH = 8'hE2;
  localparam logic [7:0] UTF8_MID_BASE   = 8'hA0;
  localparam logic [7:0] UTF8_TAIL_BASE  = 8'h80;
  localparam logic [7:0] UTF8_TAIL_MASK  = 8'h3F;
  localparam logic [7:0] ASCII_SPACE     = 8'h20;
  localparam logic [7:0] ASCII_NEWLINE   = 8'h0A;

  localparam logic [15:0] DEPTH_INF = 16'hFFFF;

  // input transaction
  typedef struct packed {
    logic [7:0]  palette;
    logic [15:0] depth;
  } pixel_t;

  // output transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] color_id_res;
    logic [7:0] dot_mask;
    logic [7:0] utf8_lead;
    logic [7:0] utf8_mid;
    logic [7:0] utf8_tail;
    logic       last;
  } result_t;

  // one cell entry of the store
  typedef struct packed {
    logic        best_col;
    logic [15:0] near_depth;
    logic [7:0]  best_color;
    logic [7:0]  mask;
  } cell_t;

  // one completed cell waiting for output
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] color;
    logic [7:0] mask;
    logic       newline;
  } cell_out_t;

  // braille dot bit of a pixel place within the cell
  function automatic logic [2:0] dot_bit(input logic sub_col, input logic [1:0] sub_row);
    logic [2:0] b;
    if (!sub_col) begin
      unique case (sub_row)
        2'd0: b = 3'd0;
        2'd1: b = 3'd1;
        2'd2: b = 3'd2;
        default: b = 3'd6;
      endcase
    end else begin
      unique case (sub_row)
        2'd0: b = 3'd3;
        2'd1: b = 3'd4;
        2'd2: b = 3'd5;
        default: b = 3'd7;
      endcase
    end
    return b;
  endfunction

endpackage

/* hdl/braille_cell_depth_encoder_core.sv */
// braille_cell_depth_encoder_core: pixel stream to braille glyph stream encoder
// Output: a cell's result passes the update stage registers and then the completed cell queue.
// Throughput: one pixel per cycle while the completed cell queue has room, set by the
// read-modify-write of the cell column memory (registered read, write-back with
// forwarding from the previous write). A band end adds one newline transaction.
// Reset: counters cleared, frame size back to 160 x 96; the cell memory is not cleared.
`timescale 1ns / 1ps

module braille_cell_depth_encoder_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bcde_pkg::pixel_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bcde_pkg::result_t                  out_data,
  input  logic                               cfg_we,
  input  logic [bcde_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bcde_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int EWW   = (bcde_pkg::FRAME_WIDTH_W > WW) ? bcde_pkg::FRAME_WIDTH_W : WW;
  localparam int EHW   = (bcde_pkg::FRAME_HEIGHT_W > HW) ? bcde_pkg::FRAME_HEIGHT_W : HW;
  localparam int CELLS = MAX_WIDTH / 2;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int QD    = 4;
  localparam int QAW   = 2;
  localparam int QCW   = 3;

  // configuration registers
  logic [bcde_pkg::FRAME_WIDTH_W-1:0]  frame_width;
  logic [bcde_pkg::FRAME_HEIGHT_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bcde_pkg::FRAME_WIDTH_RESET;
      frame_height <= bcde_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcde_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[bcde_pkg::FRAME_WIDTH_W-1:0];
        bcde_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[bcde_pkg::FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [EWW-1:0] fw_ext;
  logic [EHW-1:0] fh_ext;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;

  always_comb begin
    fw_ext = EWW'(frame_width);
    fh_ext = EHW'(frame_height);
    if (fw_ext < EWW'(2))              w = WW'(2);
    else if (fw_ext > EWW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else                               w = WW'(fw_ext);
    if (fh_ext < EHW'(4))              h = HW'(4);
    else if (fh_ext > EHW'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else                               h = HW'(fh_ext);
  end

  // raster position of the next pixel
  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;
  logic [XW-1:0] column_count_next;
  logic [YW-1:0] row_count_next;
  logic [WW:0]   x_inc;
  logic [HW:0]   y_inc;
  logic          in_accept;

  assign in_accept = in_valid && in_ready;

  always_comb begin
    x_inc             = (WW + 1)'(column_count) + (WW + 1)'(1);
    y_inc             = (HW + 1)'(row_count) + (HW + 1)'(1);
    column_count_next = XW'(x_inc);
    row_count_next    = row_count;
    if (x_inc >= (WW + 1)'(w)) begin
      column_count_next = '0;
      if (y_inc >= (HW + 1)'(h)) row_count_next = '0;
      else                       row_count_next = YW'(y_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // pixel place decode
  logic          in_frame;
  logic [AW-1:0] cell_addr;
  logic          sub_col;
  logic [1:0]    sub_row;
  logic          line_end;

  always_comb begin
    in_frame  = (WW'(column_count) < {w[WW-1:1], 1'b0}) &&
                (HW'(row_count) < {h[HW-1:2], 2'b00});
    cell_addr = AW'(column_count >> 1);
    sub_col   = column_count[0];
    sub_row   = row_count[1:0];
    line_end  = (WW'(column_count >> 1) == (WW'(w >> 1) - WW'(1)));
  end

  // update stage registers
  logic             s1_valid;
  logic [AW-1:0]    s1_addr;
  logic             s1_sub_col;
  logic [1:0]       s1_sub_row;
  logic             s1_line_end;
  bcde_pkg::pixel_t s1_pixel;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_accept && in_frame;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr     <= cell_addr;
      s1_sub_col  <= sub_col;
      s1_sub_row  <= sub_row;
      s1_line_end <= line_end;
      s1_pixel    <= in_data;
    end
  end

  // cell column memory, read at accept, written back from the update stage
  bcde_pkg::cell_t cell_store [CELLS];
  bcde_pkg::cell_t rd_data;
  bcde_pkg::cell_t cell_new;

  always_ff @(posedge clk) begin
    if (s1_valid) cell_store[s1_addr] <= cell_new;
    if (in_accept) rd_data <= cell_store[cell_addr];
  end

  // forwarding of the write that coincided with the read
  logic            fwd_valid;
  logic [AW-1:0]   fwd_addr;
  bcde_pkg::cell_t fwd_data;

  always_ff @(posedge clk) begin
    if (rst) fwd_valid <= 1'b0;
    else     fwd_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1_addr;
    fwd_data <= cell_new;
  end

  // merge the pixel into its cell
  bcde_pkg::cell_t cell_cur;
  logic            cell_end;

  always_comb begin
    priority if (!s1_sub_col && s1_sub_row == 2'd0) begin
      cell_cur            = '0;
      cell_cur.near_depth = bcde_pkg::DEPTH_INF;
    end else if (fwd_valid && fwd_addr == s1_addr) begin
      cell_cur = fwd_data;
    end else begin
      cell_cur = rd_data;
    end
    cell_new = cell_cur;
    if (s1_pixel.palette != 8'd0) begin
      cell_new.mask = cell_cur.mask |
                      (8'd1 << bcde_pkg::dot_bit(s1_sub_col, s1_sub_row));
      if (s1_pixel.depth < cell_cur.near_depth ||
          (s1_pixel.depth == cell_cur.near_depth && !s1_sub_col && cell_cur.best_col)) begin
        cell_new.near_depth = s1_pixel.depth;
        cell_new.best_color = s1_pixel.palette;
        cell_new.best_col   = s1_sub_col;
      end
    end
    cell_end = s1_valid && s1_sub_col && (s1_sub_row == 2'd3);
  end

  // completed cell queue
  bcde_pkg::cell_out_t queue [QD];
  bcde_pkg::cell_out_t push_entry;
  logic [QAW-1:0]      wr_ptr;
  logic [QAW-1:0]      rd_ptr;
  logic [QCW-1:0]      q_count;
  logic                nl_phase;
  logic                pop;

  always_comb begin
    push_entry.kind    = (cell_new.best_color != 8'd0) ? bcde_pkg::KIND_GLYPH
                                                       : bcde_pkg::KIND_BLANK;
    push_entry.color   = cell_new.best_color;
    push_entry.mask    = cell_new.mask;
    push_entry.newline = s1_line_end;
  end

  always_ff @(posedge clk) begin
    if (cell_end) queue[wr_ptr] <= push_entry;
  end

  assign out_valid = (q_count != '0);
  assign pop       = out_valid && out_ready && (!queue[rd_ptr].newline || nl_phase);
  assign in_ready  = (q_count <= QCW'(QD - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      q_count  <= '0;
      nl_phase <= 1'b0;
    end else begin
      if (cell_end) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)      rd_ptr <= rd_ptr + QAW'(1);
      q_count <= q_count + QCW'(cell_end) - QCW'(pop);
      if (out_valid && out_ready) nl_phase <= !pop;
    end
  end

  // output transaction formatting
  bcde_pkg::cell_out_t head;

  always_comb begin
    head     = queue[rd_ptr];
    out_data = '0;
    if (nl_phase) begin
      out_data.kind      = bcde_pkg::KIND_NEWLINE;
      out_data.utf8_lead = bcde_pkg::ASCII_NEWLINE;
      out_data.last      = 1'b1;
    end else if (head.kind == bcde_pkg::KIND_GLYPH) begin
      out_data.kind         = bcde_pkg::KIND_GLYPH;
      out_data.color_id_res = head.color;
      out_data.dot_mask     = head.mask;
      out_data.utf8_lead    = bcde_pkg::UTF8_LEAD_GLYPH;
      out_data.utf8_mid     = bcde_pkg::UTF8_MID_BASE | (head.mask >> 6);
      out_data.utf8_tail    = bcde_pkg::UTF8_TAIL_BASE | (head.mask & bcde_pkg::UTF8_TAIL_MASK);
      out_data.last         = !head.newline;
    end else begin
      out_data.kind      = bcde_pkg::KIND_BLANK;
      out_data.dot_mask  = head.mask;
      out_data.utf8_lead = bcde_pkg::ASCII_SPACE;
      out_data.last      = !head.newline;
    end
  end

endmodule
